FILE: rtl/exl_pkg.sv
// ----------------------------------------------------------------------------
// exl_pkg
// types, token codes and character helpers shared by the expression lexer
// ----------------------------------------------------------------------------
package exl_pkg;

  typedef enum logic [3:0] {
    KIND_LET      = 4'd0,
    KIND_IDENT    = 4'd1,
    KIND_INTEGER  = 4'd2,
    KIND_ASSIGN   = 4'd3,
    KIND_ADD      = 4'd4,
    KIND_MINUS    = 4'd5,
    KIND_MUL      = 4'd6,
    KIND_DIV      = 4'd7,
    KIND_MOD      = 4'd8,
    KIND_LPAREN   = 4'd9,
    KIND_RPAREN   = 4'd10,
    KIND_BAD_CHAR = 4'd11,
    KIND_INT_OVF  = 4'd12
  } kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_IDENT = 2'd1,
    MODE_INT   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_RUN   = 2'd0,
    ST_FLUSH = 2'd1,
    ST_DUMP  = 2'd2,
    ST_PEND  = 2'd3
  } state_t;

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_NINE       = 8'h39;
  localparam logic [7:0] CH_UPPER_A    = 8'h41;
  localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
  localparam logic [7:0] CH_LOWER_A    = 8'h61;
  localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
  localparam logic [7:0] CH_EQUAL      = 8'h3D;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_DASH       = 8'h2D;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_PERCENT    = 8'h25;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_KW_L       = 8'h6C;
  localparam logic [7:0] CH_KW_E       = 8'h65;
  localparam logic [7:0] CH_KW_T       = 8'h74;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
           ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_letter(c) || is_digit(c) || (c == CH_UNDERSCORE);
  endfunction

  function automatic logic [3:0] digit_val(input logic [7:0] c);
    logic [7:0] d;
    d = c - CH_ZERO;
    return d[3:0];
  endfunction

  function automatic kind_t sym_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      CH_EQUAL:   k = KIND_ASSIGN;
      CH_PLUS:    k = KIND_ADD;
      CH_DASH:    k = KIND_MINUS;
      CH_STAR:    k = KIND_MUL;
      CH_SLASH:   k = KIND_DIV;
      CH_PERCENT: k = KIND_MOD;
      CH_LPAREN:  k = KIND_LPAREN;
      CH_RPAREN:  k = KIND_RPAREN;
      default:    k = KIND_BAD_CHAR;
    endcase
    return k;
  endfunction

endpackage

FILE: rtl/expression_lexer.sv
// ----------------------------------------------------------------------------
// expression_lexer
// character-serial lexer for a small expression language
// ----------------------------------------------------------------------------
// One source character is taken per item together with its offset, line and
// column. Letters, digits and underscores starting with a letter or underscore
// form identifiers (the word let becomes the keyword token), digit runs form
// decimal integers, space and newline are skipped, and = + - * / % ( ) become
// symbol tokens; any other byte gives a bad-char token. An identifier comes
// out one character per item with last set on its final item. The character
// that ends a token is taken first, then the pending token is flushed (for an
// identifier this step only starts the read-back, and the kept characters
// follow one a cycle from the character memory while out_stall allows),
// then the ending character itself is handled. End of input flushes any
// pending token the same way, without that last step. Any of these steps
// stretches while the result register is held by out_stall.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module expression_lexer #(
  parameter int IDENT_MAX = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_char_code,
  input  logic                in_at_end,
  input  logic [31:0]         in_position,
  input  logic [15:0]         in_line,
  input  logic [15:0]         in_column,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [3:0]          out_kind,
  output logic [63:0]         out_value,
  output logic [31:0]         out_token_position,
  output logic [15:0]         out_token_line,
  output logic [15:0]         out_token_column,
  output logic                out_truncated,
  output logic                out_last
);

  import exl_pkg::*;

  localparam int AddrW = $clog2(IDENT_MAX);
  localparam int LenW  = $clog2(IDENT_MAX + 1);
  localparam logic [LenW-1:0] LenMax = LenW'(IDENT_MAX);
  localparam logic [LenW-1:0] LenKw  = LenW'(3);
  localparam logic [63:0] WordMask =
    (WORD_BITS >= 64) ? {64{1'b1}} : ((64'd1 << WORD_BITS) - 64'd1);

  // control and token state
  state_t            state_r, state_nxt;
  mode_t             mode_r, mode_nxt;
  logic [LenW-1:0]   len_r, len_nxt;
  logic [63:0]       acc_r, acc_nxt;
  logic              ovf_r, ovf_nxt;
  logic              let_ok_r, let_ok_nxt;
  logic [31:0]       start_pos_r, start_pos_nxt;
  logic [15:0]       start_line_r, start_line_nxt;
  logic [15:0]       start_col_r, start_col_nxt;
  logic [AddrW-1:0]  dump_idx_r, dump_idx_nxt;

  // terminating character parked while the pending token drains
  logic              pend_r, pend_nxt;
  logic [7:0]        pend_char_r, pend_char_nxt;
  logic [31:0]       pend_pos_r, pend_pos_nxt;
  logic [15:0]       pend_line_r, pend_line_nxt;
  logic [15:0]       pend_col_r, pend_col_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  kind_t             out_kind_r, out_kind_nxt;
  logic [63:0]       out_value_r, out_value_nxt;
  logic [31:0]       out_pos_r, out_pos_nxt;
  logic [15:0]       out_line_r, out_line_nxt;
  logic [15:0]       out_col_r, out_col_nxt;
  logic              out_trunc_r, out_trunc_nxt;
  logic              out_last_r, out_last_nxt;

  // character memory port
  logic              ram_we;
  logic [AddrW-1:0]  ram_wa;
  logic [7:0]        ram_wd;
  logic [AddrW-1:0]  ram_ra;
  logic [7:0]        ram_rd;

  // helpers
  logic              out_free;
  logic              load;
  logic              flush_done;
  logic              idle_go;
  logic [7:0]        src_char;
  logic [31:0]       src_pos;
  logic [15:0]       src_line;
  logic [15:0]       src_col;
  logic [67:0]       acc_x10;
  logic              kw_hit;
  logic [LenW-1:0]   dump_cnt;

  exl_ram #(
    .WIDTH (8),
    .DEPTH (IDENT_MAX)
  ) u_chars (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  // a new result can be loaded when the output slot is empty or draining
  assign out_free = !out_valid_r || !out_stall;

  // acc * 10 + digit, with the top bits showing a 64-bit overflow
  assign acc_x10 = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1) +
                   68'(digit_val(in_char_code));

  assign kw_hit   = !ovf_r && (len_r == LenKw) && let_ok_r;
  assign dump_cnt = LenW'(dump_idx_r) + LenW'(1);

  // the idle-mode handler sees either the live item or the parked character
  assign src_char = (state_r == ST_PEND) ? pend_char_r : in_char_code;
  assign src_pos  = (state_r == ST_PEND) ? pend_pos_r  : in_position;
  assign src_line = (state_r == ST_PEND) ? pend_line_r : in_line;
  assign src_col  = (state_r == ST_PEND) ? pend_col_r  : in_column;

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    len_nxt        = len_r;
    acc_nxt        = acc_r;
    ovf_nxt        = ovf_r;
    let_ok_nxt     = let_ok_r;
    start_pos_nxt  = start_pos_r;
    start_line_nxt = start_line_r;
    start_col_nxt  = start_col_r;
    dump_idx_nxt   = dump_idx_r;
    pend_nxt       = pend_r;
    pend_char_nxt  = pend_char_r;
    pend_pos_nxt   = pend_pos_r;
    pend_line_nxt  = pend_line_r;
    pend_col_nxt   = pend_col_r;

    in_stall   = 1'b1;
    ram_we     = 1'b0;
    ram_wa     = len_r[AddrW-1:0];
    ram_wd     = src_char;
    ram_ra     = dump_idx_r;
    load       = 1'b0;
    flush_done = 1'b0;
    idle_go    = 1'b0;

    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;
    out_pos_nxt   = start_pos_r;
    out_line_nxt  = start_line_r;
    out_col_nxt   = start_col_r;
    out_trunc_nxt = 1'b0;
    out_last_nxt  = 1'b1;

    case (state_r)
      ST_RUN: begin
        in_stall = !out_free;
        if (in_valid && out_free) begin
          if (in_at_end) begin
            if (mode_r != MODE_IDLE) begin
              pend_nxt  = 1'b0;
              state_nxt = ST_FLUSH;
            end
          end else begin
            case (mode_r)
              MODE_IDENT: begin
                if (is_word(in_char_code)) begin
                  // keep the character or mark the identifier too long
                  if (len_r < LenMax) begin
                    ram_we     = 1'b1;
                    len_nxt    = len_r + LenW'(1);
                    let_ok_nxt = let_ok_r &&
                      (((len_r == LenW'(1)) && (in_char_code == CH_KW_E)) ||
                       ((len_r == LenW'(2)) && (in_char_code == CH_KW_T)));
                  end else begin
                    ovf_nxt = 1'b1;
                  end
                end else begin
                  pend_nxt  = 1'b1;
                  state_nxt = ST_FLUSH;
                end
              end
              MODE_INT: begin
                if (is_digit(in_char_code)) begin
                  if (!ovf_r) begin
                    if (|acc_x10[67:64]) begin
                      ovf_nxt = 1'b1;
                    end else begin
                      acc_nxt = acc_x10[63:0];
                    end
                  end
                end else begin
                  pend_nxt  = 1'b1;
                  state_nxt = ST_FLUSH;
                end
              end
              default: begin
                idle_go = 1'b1;
              end
            endcase
          end
          // park the character in case it ends a token
          pend_char_nxt = in_char_code;
          pend_pos_nxt  = in_position;
          pend_line_nxt = in_line;
          pend_col_nxt  = in_column;
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          if (mode_r == MODE_INT) begin
            load = 1'b1;
            if (ovf_r) begin
              out_kind_nxt  = KIND_INT_OVF;
              out_value_nxt = 64'd0;
            end else begin
              out_kind_nxt  = KIND_INTEGER;
              out_value_nxt = acc_r & WordMask;
              out_trunc_nxt = |(acc_r & ~WordMask);
            end
            flush_done = 1'b1;
          end else if (kw_hit) begin
            load          = 1'b1;
            out_kind_nxt  = KIND_LET;
            out_value_nxt = 64'd0;
            flush_done    = 1'b1;
          end else begin
            // start reading the identifier back from entry zero
            ram_ra       = '0;
            dump_idx_nxt = '0;
            state_nxt    = ST_DUMP;
          end
        end
      end

      ST_DUMP: begin
        if (out_free) begin
          load          = 1'b1;
          out_kind_nxt  = KIND_IDENT;
          out_value_nxt = 64'(ram_rd);
          out_trunc_nxt = ovf_r;
          out_last_nxt  = (dump_cnt == len_r);
          dump_idx_nxt  = dump_idx_r + AddrW'(1);
          ram_ra        = dump_idx_r + AddrW'(1);
          if (dump_cnt == len_r) begin
            flush_done = 1'b1;
          end
        end
      end

      ST_PEND: begin
        if (out_free) begin
          idle_go   = 1'b1;
          state_nxt = ST_RUN;
        end
      end

      default: begin
        state_nxt = ST_RUN;
      end
    endcase

    // pending token fully delivered: back to idle, replay any parked ending character
    if (flush_done) begin
      mode_nxt  = MODE_IDLE;
      len_nxt   = '0;
      acc_nxt   = 64'd0;
      ovf_nxt   = 1'b0;
      state_nxt = pend_r ? ST_PEND : ST_RUN;
    end

    // character seen with no token pending
    if (idle_go) begin
      mode_nxt = MODE_IDLE;
      if (is_word(src_char)) begin
        start_pos_nxt  = src_pos;
        start_line_nxt = src_line;
        start_col_nxt  = src_col;
        ovf_nxt        = 1'b0;
        if (is_digit(src_char)) begin
          mode_nxt = MODE_INT;
          acc_nxt  = 64'(digit_val(src_char));
          len_nxt  = '0;
        end else begin
          mode_nxt   = MODE_IDENT;
          acc_nxt    = 64'd0;
          ram_we     = 1'b1;
          ram_wa     = '0;
          len_nxt    = LenW'(1);
          let_ok_nxt = (src_char == CH_KW_L);
        end
      end else if ((src_char != CH_SPACE) && (src_char != CH_NEWLINE)) begin
        load          = 1'b1;
        out_kind_nxt  = sym_kind(src_char);
        out_value_nxt = (sym_kind(src_char) == KIND_BAD_CHAR) ?
                        64'(src_char) : 64'd0;
        out_pos_nxt   = src_pos;
        out_line_nxt  = src_line;
        out_col_nxt   = src_col;
      end
    end

    // output slot handshake
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_RUN;
      mode_r       <= MODE_IDLE;
      len_r        <= '0;
      acc_r        <= 64'd0;
      ovf_r        <= 1'b0;
      let_ok_r     <= 1'b0;
      start_pos_r  <= 32'd0;
      start_line_r <= 16'd0;
      start_col_r  <= 16'd0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      len_r        <= len_nxt;
      acc_r        <= acc_nxt;
      ovf_r        <= ovf_nxt;
      let_ok_r     <= let_ok_nxt;
      start_pos_r  <= start_pos_nxt;
      start_line_r <= start_line_nxt;
      start_col_r  <= start_col_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    dump_idx_r  <= dump_idx_nxt;
    pend_char_r <= pend_char_nxt;
    pend_pos_r  <= pend_pos_nxt;
    pend_line_r <= pend_line_nxt;
    pend_col_r  <= pend_col_nxt;
    if (load) begin
      out_kind_r  <= out_kind_nxt;
      out_value_r <= out_value_nxt;
      out_pos_r   <= out_pos_nxt;
      out_line_r  <= out_line_nxt;
      out_col_r   <= out_col_nxt;
      out_trunc_r <= out_trunc_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_value          = out_value_r;
  assign out_token_position = out_pos_r;
  assign out_token_line     = out_line_r;
  assign out_token_column   = out_col_r;
  assign out_truncated      = out_trunc_r;
  assign out_last           = out_last_r;

endmodule

FILE: rtl/exl_ram.sv
// ----------------------------------------------------------------------------
// exl_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module exl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
